>>> hw/rtl/srpg_pkg.sv
// Shared types and constants for the stepper ramp pulse generator.
// Used by the controller, the datapath and the top level; no dependencies.
package srpg_pkg;

  localparam int TclkW = 27;
  localparam int FreqW = 16;
  localparam int StepW = 16;
  localparam int CntW = 32;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;
  localparam int InDataW = 24;
  localparam int OutDataW = 8;

  localparam int DivSteps = TclkW;
  localparam int DivCntW = $clog2(DivSteps);

  localparam logic [CfgIdxW-1:0] RegTimerClock = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRampInterval = 3'd1;
  localparam logic [CfgIdxW-1:0] RegStartFreq = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFreqInc = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMaxFreq = 3'd4;

  localparam logic OpStart = 1'b0;
  localparam logic OpTick = 1'b1;

  localparam logic [TclkW-1:0] TimerClockRst = 27'd50000000;
  localparam logic [CntW-1:0] RampIntervalRst = 32'd1000000;
  localparam logic [FreqW-1:0] StartFreqRst = 16'd5000;
  localparam logic [FreqW-1:0] FreqIncRst = 16'd1000;
  localparam logic [FreqW-1:0] MaxFreqRst = 16'd30000;

  localparam logic [FreqW-1:0] CapMidFreq = 16'd15000;
  localparam logic [FreqW-1:0] CapLowFreq = 16'd5000;
  localparam logic [StepW-1:0] LenNoCap = 16'd3000;
  localparam logic [StepW-1:0] LenMidCap = 16'd2000;

  typedef struct packed {
    logic exec;
    logic div_step;
    logic div_last;
  } cmd_t;

  typedef struct packed {
    logic need_div;
  } status_t;

endpackage

>>> hw/rtl/stepper_ramp_pulse_generator_unit.sv
// Top level of the stepper ramp pulse generator: ports and wiring of the
// controller and the datapath. Depends on srpg_pkg, srpg_ctrl, srpg_datapath.
//
// Usage: each item on the s_axis channel is either a move start (tuser 0,
// tdata holds the step count and direction) or one timer clock tick
// (tuser 1). Every item gives exactly one result on the m_axis channel with
// the step pulse, direction level and busy flag in tdata and the move-done
// flag in tlast.
// An item that needs no new step period has its result offered in the cycle
// after its input transfer. A start, or a tick that lands on a ramp update,
// has its result offered when the divide ends: the period is timer
// clock over frequency, computed by a serial divider one quotient bit per
// cycle over 27 bits.
// One item is processed at a time; the next item is taken the cycle after
// the result transfer.
// The configuration channel is ready only while no item is in flight and no
// input transfer is offered.
// Reset is synchronous and active high; it restores the register defaults
// and clears all move state. When the receiver stalls, the result is held
// and no new item or configuration write is taken.
module stepper_ramp_pulse_generator_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // Fields from bit 0: step_count[15:0], direction[16], zero pad.
  input  logic [srpg_pkg::InDataW-1:0]   s_axis_tdata,
  // Fields from bit 0: op.
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // Fields from bit 0: step_pulse[0], dir_level[1], busy_res[2], zero pad.
  output logic [srpg_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                           m_axis_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [srpg_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [srpg_pkg::CfgDataW-1:0]  cfg_data
);
  import srpg_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    res_pulse, res_dir, res_busy, res_done;

  srpg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cfg_ready (cfg_ready),
    .cmd       (cmd),
    .status    (status)
  );

  srpg_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_op     (s_axis_tuser),
    .in_count  (s_axis_tdata[StepW-1:0]),
    .in_dir    (s_axis_tdata[StepW]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_pulse (res_pulse),
    .res_dir   (res_dir),
    .res_busy  (res_busy),
    .res_done  (res_done)
  );

  assign m_axis_tdata = {{(OutDataW - 3){1'b0}}, res_busy, res_dir, res_pulse};
  assign m_axis_tlast = res_done;

endmodule

>>> hw/rtl/srpg_datapath.sv
// Datapath: configuration registers, move state, tick logic, the serial
// period divider and the result register. Depends on srpg_pkg.
module srpg_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  srpg_pkg::cmd_t                 cmd,
  output srpg_pkg::status_t              status,
  input  logic                           in_op,
  input  logic [srpg_pkg::StepW-1:0]     in_count,
  input  logic                           in_dir,
  input  logic                           cfg_we,
  input  logic [srpg_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [srpg_pkg::CfgDataW-1:0]  cfg_data,
  output logic                           res_pulse,
  output logic                           res_dir,
  output logic                           res_busy,
  output logic                           res_done
);
  import srpg_pkg::*;

  logic [TclkW-1:0] timer_clock;
  logic [CntW-1:0]  ramp_interval;
  logic [FreqW-1:0] start_freq;
  logic [FreqW-1:0] freq_inc;
  logic [FreqW-1:0] max_freq;

  logic [StepW-1:0] remaining_steps, remaining_steps_next;
  logic [StepW-1:0] requested_steps;
  logic [FreqW-1:0] current_freq, current_freq_next;
  logic [CntW-1:0]  step_period;
  logic [CntW-1:0]  period_counter, period_counter_next;
  logic [CntW-1:0]  ramp_counter, ramp_counter_next;
  logic             dir_reg;
  logic             running, running_next;

  logic [FreqW-1:0] div_divisor;
  logic [FreqW-1:0] div_rem;
  logic [TclkW-1:0] div_quo;

  logic             is_start;
  logic             is_tick;
  logic [CntW-1:0]  period_eff;
  logic [CntW-1:0]  interval_eff;
  logic             period_hit;
  logic             ramp_hit;
  logic             pulse, done;
  logic [FreqW:0]   freq_sum;
  logic [FreqW-1:0] freq_ramp;
  logic [FreqW-1:0] freq_capped;
  logic [FreqW:0]   div_shift;
  logic [FreqW:0]   div_trial;
  logic             div_ge;
  logic [FreqW-1:0] div_rem_next;
  logic [TclkW-1:0] div_quo_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_clock <= TimerClockRst;
      ramp_interval <= RampIntervalRst;
      start_freq <= StartFreqRst;
      freq_inc <= FreqIncRst;
      max_freq <= MaxFreqRst;
    end else if (cfg_we) begin
      case (cfg_index)
        RegTimerClock:   timer_clock <= cfg_data[TclkW-1:0];
        RegRampInterval: ramp_interval <= cfg_data[CntW-1:0];
        RegStartFreq:    start_freq <= cfg_data[FreqW-1:0];
        RegFreqInc:      freq_inc <= cfg_data[FreqW-1:0];
        RegMaxFreq:      max_freq <= cfg_data[FreqW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    is_start = cmd.exec && (in_op == OpStart) && (in_count != '0);
    is_tick = cmd.exec && (in_op == OpTick) && running;
    period_eff = (step_period == '0) ? CntW'(1) : step_period;
    interval_eff = (ramp_interval == '0) ? CntW'(1) : ramp_interval;
    period_hit = period_counter >= (period_eff - CntW'(1));
    ramp_hit = ramp_counter >= (interval_eff - CntW'(1));

    remaining_steps_next = period_hit ? remaining_steps - StepW'(1) : remaining_steps;
    period_counter_next = period_hit ? '0 : period_counter + CntW'(1);
    pulse = is_tick && period_hit;
    done = pulse && (remaining_steps_next == '0);
    running_next = !done;
    ramp_counter_next = ramp_hit ? '0 : ramp_counter + CntW'(1);

    freq_sum = {1'b0, current_freq} + {1'b0, freq_inc};
    if (current_freq < max_freq) begin
      freq_ramp = (freq_sum > {1'b0, max_freq}) ? max_freq : freq_sum[FreqW-1:0];
    end else begin
      freq_ramp = current_freq;
    end
    if (requested_steps > LenNoCap) begin
      freq_capped = freq_ramp;
    end else if (requested_steps > LenMidCap) begin
      freq_capped = (freq_ramp > CapMidFreq) ? CapMidFreq : freq_ramp;
    end else begin
      freq_capped = (freq_ramp > CapLowFreq) ? CapLowFreq : freq_ramp;
    end
    current_freq_next = is_start ? start_freq : freq_capped;

    status.need_div = is_start || (is_tick && !done && ramp_hit);

    div_shift = {div_rem, div_quo[TclkW-1]};
    div_trial = div_shift - {1'b0, div_divisor};
    div_ge = div_shift >= {1'b0, div_divisor};
    div_rem_next = div_ge ? div_trial[FreqW-1:0] : div_shift[FreqW-1:0];
    div_quo_next = {div_quo[TclkW-2:0], div_ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining_steps <= '0;
      requested_steps <= '0;
      current_freq <= '0;
      step_period <= '0;
      period_counter <= '0;
      ramp_counter <= '0;
      dir_reg <= 1'b0;
      running <= 1'b0;
    end else begin
      if (is_start) begin
        remaining_steps <= in_count;
        requested_steps <= in_count;
        dir_reg <= in_dir;
        current_freq <= current_freq_next;
        period_counter <= '0;
        ramp_counter <= '0;
        running <= 1'b1;
      end else if (is_tick) begin
        remaining_steps <= remaining_steps_next;
        period_counter <= period_counter_next;
        running <= running_next;
        if (running_next) begin
          ramp_counter <= ramp_counter_next;
          if (ramp_hit) begin
            current_freq <= current_freq_next;
          end
        end
      end
      if (cmd.div_last) begin
        step_period <= (div_quo_next == '0) ? CntW'(1) : CntW'(div_quo_next);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (status.need_div) begin
      div_divisor <= (current_freq_next == '0) ? FreqW'(1) : current_freq_next;
      div_rem <= '0;
      div_quo <= timer_clock;
    end else if (cmd.div_step) begin
      div_rem <= div_rem_next;
      div_quo <= div_quo_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_pulse <= pulse;
      res_dir <= is_start ? in_dir : dir_reg;
      res_busy <= is_start ? 1'b1 : (is_tick ? running_next : running);
      res_done <= done;
    end
  end

endmodule

>>> hw/rtl/srpg_ctrl.sv
// Controller state machine: sequences item intake, the serial divide and
// the result handshake. Depends on srpg_pkg.
module srpg_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              cfg_ready,
  output srpg_pkg::cmd_t    cmd,
  input  srpg_pkg::status_t status
);
  import srpg_pkg::*;

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SDiv = 2'd1;
  localparam logic [1:0] SOut = 2'd2;

  logic [1:0]         state, state_next;
  logic [DivCntW-1:0] div_cnt, div_cnt_next;

  always_comb begin
    state_next = state;
    div_cnt_next = div_cnt;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    cfg_ready = 1'b0;
    case (state)
      SIdle: begin
        in_ready = 1'b1;
        cfg_ready = !in_valid;
        if (in_valid) begin
          cmd.exec = 1'b1;
          if (status.need_div) begin
            state_next = SDiv;
            div_cnt_next = DivCntW'(DivSteps - 1);
          end else begin
            state_next = SOut;
          end
        end
      end
      SDiv: begin
        cmd.div_step = 1'b1;
        if (div_cnt == '0) begin
          cmd.div_last = 1'b1;
          state_next = SOut;
        end else begin
          div_cnt_next = div_cnt - DivCntW'(1);
        end
      end
      SOut: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = SIdle;
        end
      end
      default: state_next = SIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      div_cnt <= '0;
    end else begin
      state <= state_next;
      div_cnt <= div_cnt_next;
    end
  end

  a_div_entry: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && status.need_div) |=> (state == SDiv && div_cnt == DivCntW'(DivSteps - 1)))
    else $error("divide not started after an item that needs a new period");

  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    cmd.div_last |=> out_valid)
    else $error("result not offered after the last divide step");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid) && !(cmd.div_step && cmd.exec))
    else $error("intake overlaps a divide or a pending result");

endmodule
